/* rtl/core/htpc_pkg.sv */
// ----------------------------------------------------------------------------
// htpc_pkg
// Shared types, codes and constants for the heading turn PID controller:
// operation and motor command codes, register indexes, config and queue
// word structs, and the angle wrap helper.
// ----------------------------------------------------------------------------
package htpc_pkg;

  // Operation codes of an input word
  typedef enum logic [1:0] {
    OP_SAMPLE = 2'd0,
    OP_LEFT   = 2'd1,
    OP_RIGHT  = 2'd2,
    OP_STOP   = 2'd3
  } op_e;

  // Motor command codes of a result word
  typedef enum logic [1:0] {
    MC_NONE  = 2'd0,
    MC_LEFT  = 2'd1,
    MC_RIGHT = 2'd2,
    MC_STOP  = 2'd3
  } motor_cmd_e;

  // Configuration port
  localparam int unsigned REG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [REG_IDX_W-1:0] REG_GAIN_P          = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_GAIN_I          = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_GAIN_D          = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_ANGLE_TOLERANCE = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_SPEED_CEILING   = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_SPEED_FLOOR     = 3'd5;

  // Field widths
  localparam int unsigned ANGLE_W = 16;
  localparam int unsigned GAIN_W  = 16;
  localparam int unsigned TOL_W   = 15;
  localparam int unsigned SPEED_W = 7;

  // Angle arithmetic in centidegrees, with headroom for one wrap step
  localparam int unsigned WIDE_ANGLE_W = 18;
  localparam logic signed [WIDE_ANGLE_W-1:0] HALF_TURN    = 18'sd18000;
  localparam logic signed [WIDE_ANGLE_W-1:0] FULL_TURN    = 18'sd36000;
  localparam logic signed [WIDE_ANGLE_W-1:0] QUARTER_TURN = 18'sd9000;

  // PID datapath widths
  localparam int unsigned E100_W    = 22;  // error * 100
  localparam int unsigned DIFF_W    = 17;  // error - last error
  localparam int unsigned DD_W      = 30;  // (error - last error) * 10000
  localparam int unsigned NUM_W     = 64;  // PID numerator
  localparam int unsigned ICLAMP_W  = 62;  // integral term after clamp to 2^60
  localparam int unsigned ILIM_BITS = 60;

  // Speed scaling: percent = numerator / 2560000 = (numerator >> 12) / 625
  localparam int unsigned SCALE_W     = 22;
  localparam logic [SCALE_W-1:0] PID_SCALE = 22'd2560000;
  localparam int unsigned MAGC_W      = 29;  // 127 * 2560000 fits
  localparam int unsigned SCALE_SHIFT = 12;
  localparam int unsigned QX_W        = MAGC_W - SCALE_SHIFT;
  localparam int unsigned RECIP_W     = 18;
  localparam logic [RECIP_W-1:0] RECIP_625 = 18'd214749;  // ceil(2^27 / 625)
  localparam int unsigned RECIP_SHIFT = 27;
  localparam int unsigned QPROD_W     = QX_W + RECIP_W;

  // Queue between front and back
  localparam int unsigned QUEUE_DEPTH = 4;

  // Configuration registers as one group
  typedef struct packed {
    logic [GAIN_W-1:0]  gain_p;
    logic [GAIN_W-1:0]  gain_i;
    logic [GAIN_W-1:0]  gain_d;
    logic [TOL_W-1:0]   angle_tolerance;
    logic [SPEED_W-1:0] speed_ceiling;
    logic [SPEED_W-1:0] speed_floor;
  } htpc_cfg_t;

  // Classified word handed from front to back
  typedef struct packed {
    logic                      pid_run;    // run the PID on err
    logic                      use_speed;  // report the PID speed
    motor_cmd_e                cmd;
    logic signed [ANGLE_W-1:0] err;
    logic                      reached;
    logic                      turning;
  } htpc_entry_t;

  // Bring an angle back into -18000..+18000 (one step covers the ranges its callers pass)
  function automatic logic signed [WIDE_ANGLE_W-1:0] wrap_angle(
    input logic signed [WIDE_ANGLE_W-1:0] a
  );
    logic signed [WIDE_ANGLE_W-1:0] r;
    r = a;
    if (a > HALF_TURN) begin
      r = a - FULL_TURN;
    end else if (a < -HALF_TURN) begin
      r = a + FULL_TURN;
    end
    return r;
  endfunction

endpackage

/* rtl/core/htpc_queue.sv */
// ----------------------------------------------------------------------------
// htpc_queue
// Short first-in first-out queue of classified words between the front
// and the back, so that each side stalls on its own.
// ----------------------------------------------------------------------------
module htpc_queue import htpc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  htpc_entry_t entry_i,
  output logic        full_o,
  input  logic        pop_i,
  output logic        empty_o,
  output htpc_entry_t head_o
);

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

  htpc_entry_t       slots_q [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic              do_push, do_pop;

  assign full_o  = (count_q == FULL_CNT);
  assign empty_o = (count_q == '0);
  assign head_o  = slots_q[rd_ptr_q];

  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  // Advance pointers and fill count
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store the pushed word
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slots_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule

/* rtl/core/htpc_front.sv */
// ----------------------------------------------------------------------------
// htpc_front
// Accepts input words, keeps the heading, target and turn state, wraps the
// heading error, checks tolerance and classifies each word for the back.
// ----------------------------------------------------------------------------
module htpc_front import htpc_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [1:0]                operation_i,
  input  logic signed [ANGLE_W-1:0] yaw_sample_i,
  input  logic [TOL_W-1:0]          tolerance_i,
  input  logic                      q_full_i,
  output logic                      push_o,
  output htpc_entry_t               entry_o
);

  logic signed [ANGLE_W-1:0] heading_q, heading_d;
  logic signed [ANGLE_W-1:0] target_q, target_d;
  logic                      active_q, active_d;
  motor_cmd_e                sense_q, sense_d;

  logic                           accept;
  op_e                            op;
  logic signed [WIDE_ANGLE_W-1:0] turn_sum;
  logic signed [WIDE_ANGLE_W-1:0] err_wide;
  logic [WIDE_ANGLE_W-1:0]        err_mag;
  logic                           rotating;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  assign push_o     = accept;
  assign op         = op_e'(operation_i);

  // Candidate target and error for this word
  always_comb begin
    if (op == OP_LEFT) begin
      turn_sum = WIDE_ANGLE_W'(heading_q) + QUARTER_TURN;
    end else begin
      turn_sum = WIDE_ANGLE_W'(heading_q) - QUARTER_TURN;
    end
    err_wide = wrap_angle(WIDE_ANGLE_W'(target_q) - WIDE_ANGLE_W'(yaw_sample_i));
    err_mag  = err_wide[WIDE_ANGLE_W-1] ? WIDE_ANGLE_W'(-err_wide) : err_wide;
    rotating = (sense_q == MC_LEFT) || (sense_q == MC_RIGHT);
  end

  // Classify the word and update the turn state
  always_comb begin
    heading_d = heading_q;
    target_d  = target_q;
    active_d  = active_q;
    sense_d   = sense_q;
    entry_o   = '0;
    entry_o.cmd = MC_NONE;
    case (op)
      OP_LEFT, OP_RIGHT: begin
        target_d = ANGLE_W'(wrap_angle(turn_sum));
        active_d = 1'b1;
        sense_d  = (op == OP_LEFT) ? MC_LEFT : MC_RIGHT;
        entry_o.turning = 1'b1;
      end
      OP_STOP: begin
        active_d    = 1'b0;
        sense_d     = MC_NONE;
        entry_o.cmd = MC_STOP;
      end
      default: begin
        heading_d = yaw_sample_i;
        if (active_q) begin
          entry_o.err = ANGLE_W'(err_wide);
          if (err_mag <= WIDE_ANGLE_W'(tolerance_i)) begin
            active_d        = 1'b0;
            sense_d         = MC_NONE;
            entry_o.cmd     = MC_STOP;
            entry_o.reached = 1'b1;
          end else begin
            entry_o.pid_run   = 1'b1;
            entry_o.use_speed = rotating;
            entry_o.cmd       = rotating ? sense_q : MC_NONE;
            entry_o.turning   = 1'b1;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      heading_q <= '0;
      target_q  <= '0;
      active_q  <= 1'b0;
      sense_q   <= MC_NONE;
    end else if (accept) begin
      heading_q <= heading_d;
      target_q  <= target_d;
      active_q  <= active_d;
      sense_q   <= sense_d;
    end
  end

endmodule

/* rtl/core/htpc_back.sv */
// ----------------------------------------------------------------------------
// htpc_back
// Pipelined PID: integral and last-error update, gain multiplies, term
// sum, magnitude, clamp to ceiling and floor, scaling to percent, and the
// output register of the result word.
// ----------------------------------------------------------------------------
module htpc_back import htpc_pkg::*; #(
  parameter int unsigned SUM_WIDTH = 32
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  htpc_cfg_t                 cfg_i,
  input  logic                      q_empty_i,
  input  htpc_entry_t               q_entry_i,
  output logic                      pop_o,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [1:0]                motor_command_o,
  output logic [SPEED_W-1:0]        motor_speed_o,
  output logic signed [ANGLE_W-1:0] heading_error_o,
  output logic                      target_reached_o,
  output logic                      turning_o
);

  localparam int unsigned LO_W  = SUM_WIDTH / 2;
  localparam int unsigned HI_W  = SUM_WIDTH - LO_W;
  localparam int unsigned P_W   = GAIN_W + 1 + E100_W;
  localparam int unsigned D_W   = GAIN_W + 1 + DD_W;
  localparam int unsigned ILO_W = GAIN_W + LO_W;
  localparam int unsigned IHI_W = GAIN_W + 1 + HI_W;
  localparam int unsigned IT_W  = SUM_WIDTH + GAIN_W + 2;
  localparam int unsigned EXT_W = (IT_W > ICLAMP_W) ? IT_W : ICLAMP_W;

  localparam logic signed [SUM_WIDTH:0] SUM_MAX = {2'b00, {(SUM_WIDTH-1){1'b1}}};
  localparam logic signed [SUM_WIDTH:0] SUM_MIN = {2'b11, {(SUM_WIDTH-1){1'b0}}};
  localparam logic signed [EXT_W-1:0]   I_POS   = EXT_W'({1'b1, {ILIM_BITS{1'b0}}});
  localparam logic signed [EXT_W-1:0]   I_NEG   = -I_POS;

  logic advance;

  // PID state
  logic signed [SUM_WIDTH-1:0] err_sum_q;
  logic signed [ANGLE_W-1:0]   last_err_q;

  // Stage registers
  logic                        s1_valid_q, s2_valid_q, s3_valid_q;
  logic                        s4_valid_q, s5_valid_q, s6_valid_q;
  htpc_entry_t                 s1_ent_q, s2_ent_q, s3_ent_q, s4_ent_q, s5_ent_q, s6_ent_q;
  logic signed [E100_W-1:0]    s1_e100_q;
  logic signed [DD_W-1:0]      s1_dd_q;
  logic signed [SUM_WIDTH-1:0] s1_sum_q;
  logic signed [P_W-1:0]       s2_p_q;
  logic signed [D_W-1:0]       s2_d_q;
  logic [ILO_W-1:0]            s2_ilo_q;
  logic signed [IHI_W-1:0]     s2_ihi_q;
  logic signed [ICLAMP_W-1:0]  s3_icl_q;
  logic signed [NUM_W-1:0]     s3_pd_q;
  logic signed [NUM_W-1:0]     s4_num_q;
  logic [NUM_W-1:0]            s5_mag_q;
  logic [MAGC_W-1:0]           s6_magc_q;
  logic                        s6_low_q;
  logic                        out_valid_q;

  // Stage logic
  logic signed [SUM_WIDTH:0]   sum_ext;
  logic signed [SUM_WIDTH-1:0] sum_sat;
  logic signed [E100_W-1:0]    e100;
  logic signed [DIFF_W-1:0]    diff;
  logic signed [DD_W-1:0]      dd;
  logic signed [P_W-1:0]       p_prod;
  logic signed [D_W-1:0]       d_prod;
  logic [ILO_W-1:0]            ilo_prod;
  logic signed [IHI_W-1:0]     ihi_prod;
  logic signed [IT_W-1:0]      iterm;
  logic signed [EXT_W-1:0]     iterm_ext;
  logic signed [ICLAMP_W-1:0]  iterm_cl;
  logic [NUM_W-1:0]            mag;
  logic [MAGC_W-1:0]           ceil_n, floor_n, magc;
  logic [QX_W-1:0]             qx;
  logic [QPROD_W-1:0]          qprod;
  logic [SPEED_W-1:0]          quot, speed;

  // Whole pipeline moves when the output register is free
  assign advance     = !out_valid_q || out_ready_i;
  assign pop_o       = advance && !q_empty_i;
  assign out_valid_o = out_valid_q;

  // Stage 1: saturating integral, scaled error and scaled difference
  always_comb begin
    sum_ext = (SUM_WIDTH+1)'(err_sum_q) + (SUM_WIDTH+1)'(q_entry_i.err);
    if (sum_ext > SUM_MAX) begin
      sum_sat = SUM_WIDTH'(SUM_MAX);
    end else if (sum_ext < SUM_MIN) begin
      sum_sat = SUM_WIDTH'(SUM_MIN);
    end else begin
      sum_sat = SUM_WIDTH'(sum_ext);
    end
    e100 = E100_W'(q_entry_i.err) * E100_W'(100);
    diff = DIFF_W'(q_entry_i.err) - DIFF_W'(last_err_q);
    dd   = DD_W'(diff) * DD_W'(10000);
  end

  // Stage 2: gain multiplies, integral split in two partial products
  always_comb begin
    p_prod   = $signed({1'b0, cfg_i.gain_p}) * s1_e100_q;
    d_prod   = $signed({1'b0, cfg_i.gain_d}) * s1_dd_q;
    ilo_prod = cfg_i.gain_i * s1_sum_q[LO_W-1:0];
    ihi_prod = $signed({1'b0, cfg_i.gain_i}) * $signed(s1_sum_q[SUM_WIDTH-1:LO_W]);
  end

  // Stage 3: join integral partials and clamp; add P and D terms
  always_comb begin
    iterm     = (IT_W'(s2_ihi_q) <<< LO_W) + $signed(IT_W'(s2_ilo_q));
    iterm_ext = EXT_W'(iterm);
    if (iterm_ext > I_POS) begin
      iterm_cl = ICLAMP_W'(I_POS);
    end else if (iterm_ext < I_NEG) begin
      iterm_cl = ICLAMP_W'(I_NEG);
    end else begin
      iterm_cl = ICLAMP_W'(iterm_ext);
    end
  end

  // Stage 5: magnitude of the numerator
  assign mag = s4_num_q[NUM_W-1] ? NUM_W'(-s4_num_q) : s4_num_q;

  // Stage 6: clamp to the ceiling, flag values under the floor
  always_comb begin
    ceil_n  = cfg_i.speed_ceiling * PID_SCALE;
    floor_n = cfg_i.speed_floor * PID_SCALE;
    magc    = (s5_mag_q > NUM_W'(ceil_n)) ? ceil_n : s5_mag_q[MAGC_W-1:0];
  end

  // Stage 7: divide by the scale through a reciprocal, apply the floor
  always_comb begin
    qx    = s6_magc_q[MAGC_W-1:SCALE_SHIFT];
    qprod = qx * RECIP_625;
    quot  = qprod[RECIP_SHIFT+SPEED_W-1:RECIP_SHIFT];
    speed = s6_low_q ? cfg_i.speed_floor : quot;
  end

  // Hold valid bits, PID state and the output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      err_sum_q   <= '0;
      last_err_q  <= '0;
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      s3_valid_q  <= 1'b0;
      s4_valid_q  <= 1'b0;
      s5_valid_q  <= 1'b0;
      s6_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (advance) begin
      s1_valid_q  <= pop_o;
      s2_valid_q  <= s1_valid_q;
      s3_valid_q  <= s2_valid_q;
      s4_valid_q  <= s3_valid_q;
      s5_valid_q  <= s4_valid_q;
      s6_valid_q  <= s5_valid_q;
      out_valid_q <= s6_valid_q;
      if (pop_o && q_entry_i.pid_run) begin
        err_sum_q  <= sum_sat;
        last_err_q <= q_entry_i.err;
      end
    end
  end

  // Advance the datapath
  always_ff @(posedge clk_i) begin
    if (advance) begin
      s1_ent_q  <= q_entry_i;
      s1_e100_q <= e100;
      s1_dd_q   <= dd;
      s1_sum_q  <= sum_sat;
      s2_ent_q  <= s1_ent_q;
      s2_p_q    <= p_prod;
      s2_d_q    <= d_prod;
      s2_ilo_q  <= ilo_prod;
      s2_ihi_q  <= ihi_prod;
      s3_ent_q  <= s2_ent_q;
      s3_icl_q  <= iterm_cl;
      s3_pd_q   <= NUM_W'(s2_p_q) + NUM_W'(s2_d_q);
      s4_ent_q  <= s3_ent_q;
      s4_num_q  <= s3_pd_q + NUM_W'(s3_icl_q);
      s5_ent_q  <= s4_ent_q;
      s5_mag_q  <= mag;
      s6_ent_q  <= s5_ent_q;
      s6_magc_q <= magc;
      s6_low_q  <= (magc < floor_n);
      if (s6_valid_q) begin
        motor_command_o  <= s6_ent_q.cmd;
        motor_speed_o    <= s6_ent_q.use_speed ? speed : '0;
        heading_error_o  <= s6_ent_q.err;
        target_reached_o <= s6_ent_q.reached;
        turning_o        <= s6_ent_q.turning;
      end
    end
  end

endmodule

/* rtl/core/heading_turn_pid_controller_core.sv */
// ----------------------------------------------------------------------------
// heading_turn_pid_controller_core
// Heading turn controller: 90 degree turns toward a wrapped target heading,
// PID speed with clamp to ceiling and floor, one result word per input word.
// ----------------------------------------------------------------------------
// Path: input accept, queue, six PID stages, output register, then result valid;
//   a stalled output holds the whole pipeline.
// Throughput: one word per cycle while the queue has room; the front and back meet
//   through a four-word queue, so input is taken while a result waits, until full.
// Reset: asynchronous, active low; clears heading, target, turn, integral and
//   last error state, empties the pipeline and loads the register defaults.
module heading_turn_pid_controller_core import htpc_pkg::*; #(
  parameter int unsigned SUM_WIDTH = 32
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // configuration write port
  input  logic                      cfg_we_i,
  input  logic [REG_IDX_W-1:0]      cfg_index_i,
  input  logic [CFG_DATA_W-1:0]     cfg_data_i,
  // input words
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [1:0]                operation_i,
  input  logic signed [ANGLE_W-1:0] yaw_sample_i,
  // result words
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [1:0]                motor_command_o,
  output logic [SPEED_W-1:0]        motor_speed_o,
  output logic signed [ANGLE_W-1:0] heading_error_o,
  output logic                      target_reached_o,
  output logic                      turning_o
);

  htpc_cfg_t   cfg_q;
  logic        q_push, q_full, q_pop, q_empty;
  htpc_entry_t q_in, q_head;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gain_p          <= 16'd512;
      cfg_q.gain_i          <= 16'd26;
      cfg_q.gain_d          <= 16'd128;
      cfg_q.angle_tolerance <= 15'd200;
      cfg_q.speed_ceiling   <= 7'd50;
      cfg_q.speed_floor     <= 7'd10;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_GAIN_P:          cfg_q.gain_p          <= cfg_data_i;
        REG_GAIN_I:          cfg_q.gain_i          <= cfg_data_i;
        REG_GAIN_D:          cfg_q.gain_d          <= cfg_data_i;
        REG_ANGLE_TOLERANCE: cfg_q.angle_tolerance <= cfg_data_i[TOL_W-1:0];
        REG_SPEED_CEILING:   cfg_q.speed_ceiling   <= cfg_data_i[SPEED_W-1:0];
        REG_SPEED_FLOOR:     cfg_q.speed_floor     <= cfg_data_i[SPEED_W-1:0];
        default: ;
      endcase
    end
  end

  htpc_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .operation_i  (operation_i),
    .yaw_sample_i (yaw_sample_i),
    .tolerance_i  (cfg_q.angle_tolerance),
    .q_full_i     (q_full),
    .push_o       (q_push),
    .entry_o      (q_in)
  );

  htpc_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .entry_i (q_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .head_o  (q_head)
  );

  htpc_back #(
    .SUM_WIDTH (SUM_WIDTH)
  ) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_i            (cfg_q),
    .q_empty_i        (q_empty),
    .q_entry_i        (q_head),
    .pop_o            (q_pop),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .motor_command_o  (motor_command_o),
    .motor_speed_o    (motor_speed_o),
    .heading_error_o  (heading_error_o),
    .target_reached_o (target_reached_o),
    .turning_o        (turning_o)
  );

  // A reached target stops the motor and ends the turn
  a_reached_stops : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && target_reached_o |->
      motor_command_o == MC_STOP && !turning_o && motor_speed_o == '0)
    else $error("reached word without stop");

  // Only rotate commands carry a speed
  a_speed_needs_rotate : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && motor_speed_o != '0 |->
      motor_command_o == MC_LEFT || motor_command_o == MC_RIGHT)
    else $error("speed on a non-rotate command");

  // Rotate speed stays between floor and ceiling, the floor winning
  a_speed_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (motor_command_o == MC_LEFT || motor_command_o == MC_RIGHT) |->
      motor_speed_o >= cfg_q.speed_floor &&
      (motor_speed_o <= cfg_q.speed_ceiling || motor_speed_o == cfg_q.speed_floor))
    else $error("rotate speed outside floor and ceiling");

endmodule

/* tb/sv/htpc_tb_pkg.sv */
// ----------------------------------------------------------------------------
// htpc_tb_pkg
// Scoreboard for the heading turn PID controller: a cycle-free model of the
// turn state, integral and speed clamps that predicts one result word per
// accepted input word and checks the block's words in order.
// ----------------------------------------------------------------------------
package htpc_tb_pkg;
  import htpc_pkg::*;

  // Integral width used for both the block and the prediction
  localparam int SUM_W = 32;

  localparam int HALF_CDEG    = 18000;
  localparam int FULL_CDEG    = 36000;
  localparam int QUARTER_CDEG = 9000;
  localparam longint SPEED_SCALE = 2560000;

  // One expected result word
  typedef struct packed {
    motor_cmd_e                cmd;
    logic [SPEED_W-1:0]        speed;
    logic signed [ANGLE_W-1:0] err;
    logic                      reached;
    logic                      turning;
  } motor_word_t;

  // Fold an angle into -18000..+18000 centidegrees
  function automatic int wrap_cdeg(int a);
    while (a > HALF_CDEG) a -= FULL_CDEG;
    while (a < -HALF_CDEG) a += FULL_CDEG;
    return a;
  endfunction

  class heading_scoreboard;
    // register copies
    int gain_p, gain_i, gain_d, tolerance, spd_ceil, spd_floor;
    // controller state
    int         heading, target, last_err;
    bit         active;
    motor_cmd_e sense;
    longint     err_sum;
    // words still owed by the block
    motor_word_t awaited[$];
    int words_in, words_out, mismatches, hits;

    function new();
      gain_p    = 512;
      gain_i    = 26;
      gain_d    = 128;
      tolerance = 200;
      spd_ceil  = 50;
      spd_floor = 10;
      heading   = 0;
      target    = 0;
      last_err  = 0;
      active    = 0;
      sense     = MC_NONE;
      err_sum   = 0;
      words_in  = 0;
      words_out = 0;
      mismatches = 0;
      hits      = 0;
    endfunction

    // Mirror a register write, keeping only the register's own bits
    function void set_reg(logic [REG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_GAIN_P:          gain_p    = int'(data);
        REG_GAIN_I:          gain_i    = int'(data);
        REG_GAIN_D:          gain_d    = int'(data);
        REG_ANGLE_TOLERANCE: tolerance = int'(data[TOL_W-1:0]);
        REG_SPEED_CEILING:   spd_ceil  = int'(data[SPEED_W-1:0]);
        REG_SPEED_FLOOR:     spd_floor = int'(data[SPEED_W-1:0]);
        default: ;
      endcase
    endfunction

    function int pending();
      return awaited.size();
    endfunction

    // Advance the integral and derivative state and return the speed in percent
    function int pid_speed(int e);
      longint smax, smin, lim, s, pterm, iterm, dterm, num, mag, ceil_n;
      int spd;
      smax = (longint'(1) << (SUM_W - 1)) - 1;
      smin = -smax - 1;
      lim  = longint'(1) << 60;
      // saturate the running error sum
      s = err_sum + e;
      if (s > smax) s = smax;
      if (s < smin) s = smin;
      err_sum = s;
      pterm = longint'(gain_p) * e * 100;
      iterm = longint'(gain_i) * err_sum;
      if (iterm > lim) iterm = lim;
      if (iterm < -lim) iterm = -lim;
      dterm = longint'(gain_d) * (longint'(e) - last_err) * 10000;
      last_err = e;
      // clamp to the ceiling first, then raise to the floor
      num = pterm + iterm + dterm;
      mag = (num < 0) ? -num : num;
      ceil_n = longint'(spd_ceil) * SPEED_SCALE;
      if (mag > ceil_n) mag = ceil_n;
      if (mag < longint'(spd_floor) * SPEED_SCALE) spd = spd_floor;
      else spd = int'(mag / SPEED_SCALE);
      return spd & 127;
    endfunction

    // Predict the result of one accepted input word
    function void note_word(op_e op, logic signed [ANGLE_W-1:0] yaw);
      motor_word_t w;
      int e, mag, spd;
      w.cmd = MC_NONE;
      w.speed = '0;
      w.err = '0;
      w.reached = 1'b0;
      words_in++;
      case (op)
        OP_LEFT, OP_RIGHT: begin
          target = wrap_cdeg(heading + ((op == OP_LEFT) ? QUARTER_CDEG : -QUARTER_CDEG));
          active = 1;
          sense  = (op == OP_LEFT) ? MC_LEFT : MC_RIGHT;
        end
        OP_STOP: begin
          active = 0;
          sense  = MC_NONE;
          w.cmd  = MC_STOP;
        end
        default: begin
          heading = int'(yaw);
          if (active) begin
            e = wrap_cdeg(target - heading);
            mag = (e < 0) ? -e : e;
            w.err = ANGLE_W'(e);
            if (mag <= tolerance) begin
              // close enough: stop and end the turn
              active    = 0;
              sense     = MC_NONE;
              w.cmd     = MC_STOP;
              w.reached = 1'b1;
              hits++;
            end else begin
              spd = pid_speed(e);
              if (sense != MC_NONE) begin
                w.cmd   = sense;
                w.speed = SPEED_W'(spd);
              end
            end
          end
        end
      endcase
      w.turning = active;
      awaited.push_back(w);
    endfunction

    // Print one mismatch line, quietly beyond the first few dozen
    task report(string msg);
      if (mismatches < 30) $display("mismatch: %s", msg);
      mismatches++;
    endtask

    // Compare one result word with the oldest prediction
    task check_word(logic [1:0] cmd, logic [SPEED_W-1:0] spd,
                    logic signed [ANGLE_W-1:0] err, logic reached, logic turning);
      motor_word_t w;
      words_out++;
      if (awaited.size() == 0) begin
        report($sformatf("word %0d arrived with nothing owed (cmd=%0d spd=%0d err=%0d)",
                         words_out, cmd, spd, err));
        return;
      end
      w = awaited.pop_front();
      if (cmd !== w.cmd || spd !== w.speed || err !== w.err ||
          reached !== w.reached || turning !== w.turning) begin
        report($sformatf({"word %0d: exp cmd=%0d spd=%0d err=%0d hit=%0d turn=%0d, ",
                          "got cmd=%0d spd=%0d err=%0d hit=%0d turn=%0d"},
                         words_out, w.cmd, w.speed, w.err, w.reached, w.turning,
                         cmd, spd, err, reached, turning));
      end
    endtask
  endclass

endpackage

/* tb/sv/tb_heading_turn_pid_controller_core.sv */
// ----------------------------------------------------------------------------
// tb_heading_turn_pid_controller_core
// Drives yaw samples and turn commands into the heading controller under
// random valid/ready idling, walks through several register settings and
// checks every result word against the scoreboard's prediction.
// ----------------------------------------------------------------------------
module tb_heading_turn_pid_controller_core;
  import htpc_pkg::*;
  import htpc_tb_pkg::*;

  localparam int QUIET_LIMIT     = 4000;
  localparam int PHASES          = 7;
  localparam int WORDS_PER_PHASE = 58;

  logic                      clk_i;
  logic                      rst_ni;
  logic                      cfg_we_i;
  logic [REG_IDX_W-1:0]      cfg_index_i;
  logic [CFG_DATA_W-1:0]     cfg_data_i;
  logic                      in_valid_i;
  logic                      in_ready_o;
  logic [1:0]                operation_i;
  logic signed [ANGLE_W-1:0] yaw_sample_i;
  logic                      out_valid_o;
  logic                      out_ready_i;
  logic [1:0]                motor_command_o;
  logic [SPEED_W-1:0]        motor_speed_o;
  logic signed [ANGLE_W-1:0] heading_error_o;
  logic                      target_reached_o;
  logic                      turning_o;

  heading_scoreboard sb;
  bit calm;
  int quiet_cycles = 0;
  int settings_used = 0;

  heading_turn_pid_controller_core #(
    .SUM_WIDTH(SUM_W)
  ) dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .operation_i      (operation_i),
    .yaw_sample_i     (yaw_sample_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .motor_command_o  (motor_command_o),
    .motor_speed_o    (motor_speed_o),
    .heading_error_o  (heading_error_o),
    .target_reached_o (target_reached_o),
    .turning_o        (turning_o)
  );

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Result side: stall in bursts, never once the run has gone calm
  initial begin
    out_ready_i <= 1'b0;
    while (rst_ni !== 1'b1) @(posedge clk_i);
    forever begin
      if (!calm && $urandom_range(0, 2) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      repeat ($urandom_range(1, 30)) @(posedge clk_i);
    end
  end

  // Check each accepted result word
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      sb.check_word(motor_command_o, motor_speed_o, heading_error_o,
                    target_reached_o, turning_o);
    end
  end

  // Drop the run when no word moves for too long
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("watchdog: no word moved for %0d cycles", QUIET_LIMIT);
      $display("status: fail");
      $finish;
    end
  end

  function automatic logic signed [ANGLE_W-1:0] any_yaw();
    return ANGLE_W'($urandom_range(0, 65535));
  endfunction

  // Offer one input word, with an optional gap first, and hold it until taken
  task automatic send_word(input op_e op, input logic signed [ANGLE_W-1:0] yaw);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    operation_i  <= op;
    yaw_sample_i <= yaw;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_word(op, yaw);
  endtask

  // Hold off input until every owed word has come back
  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [REG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    sb.set_reg(idx, data);
    @(posedge clk_i);
  endtask

  // Load all six registers while the block is idle
  task automatic program_regs(input int gp, input int gi, input int gd,
                              input int tol, input int sc, input int sf);
    drain();
    write_reg(REG_GAIN_P, CFG_DATA_W'(gp));
    write_reg(REG_GAIN_I, CFG_DATA_W'(gi));
    write_reg(REG_GAIN_D, CFG_DATA_W'(gd));
    write_reg(REG_ANGLE_TOLERANCE, CFG_DATA_W'(tol));
    write_reg(REG_SPEED_CEILING, CFG_DATA_W'(sc));
    write_reg(REG_SPEED_FLOOR, CFG_DATA_W'(sf));
    cfg_we_i <= 1'b0;
    settings_used++;
  endtask

  task automatic start_turn();
    if ($urandom_range(0, 1)) send_word(OP_LEFT, any_yaw());
    else send_word(OP_RIGHT, any_yaw());
  endtask

  // One turn: command, noisy samples closing in on target, maybe a stop or new turn
  task automatic run_turn();
    int steps, e0, e, k;
    bit done;
    logic signed [ANGLE_W-1:0] yaw;
    done = 0;
    start_turn();
    e0 = wrap_cdeg(sb.target - sb.heading);
    steps = $urandom_range(2, 10);
    for (k = 1; k <= steps && !done; k++) begin
      e = e0 * (steps - k) / steps + int'($urandom_range(0, 400)) - 200;
      yaw = ANGLE_W'(wrap_cdeg(sb.target - e));
      case ($urandom_range(0, 19))
        0: send_word(OP_SAMPLE, any_yaw());
        1: begin
          send_word(OP_STOP, any_yaw());
          done = 1;
        end
        2: begin
          start_turn();
          e0 = wrap_cdeg(sb.target - sb.heading);
        end
        default: send_word(OP_SAMPLE, yaw);
      endcase
    end
  endtask

  // Mostly turn sequences, some idle samples and stray stops
  task automatic run_phase(input int n);
    int stop_at, pick;
    stop_at = sb.words_in + n;
    while (sb.words_in < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) run_turn();
      else if (pick < 80) send_word(OP_SAMPLE, any_yaw());
      else if (pick < 90)
        send_word(OP_SAMPLE, ANGLE_W'(int'($urandom_range(0, 36000)) - HALF_CDEG));
      else send_word(OP_STOP, any_yaw());
    end
  endtask

  // Edge headings, wrap across the half turn, tolerance boundary, every command
  task automatic run_directed();
    send_word(OP_SAMPLE, 16'sd0);
    send_word(OP_SAMPLE, 16'sd18000);
    send_word(OP_LEFT, any_yaw());
    send_word(OP_SAMPLE, -16'sd18000);
    send_word(OP_SAMPLE, -16'sd9100);
    send_word(OP_RIGHT, any_yaw());
    send_word(OP_SAMPLE, 16'sh7FFF);
    send_word(OP_SAMPLE, 16'sh8000);
    send_word(OP_SAMPLE, 16'sd17600);
    send_word(OP_LEFT, any_yaw());
    send_word(OP_SAMPLE, -16'sd18000);
    send_word(OP_STOP, any_yaw());
    send_word(OP_STOP, any_yaw());
    send_word(OP_SAMPLE, -16'sd18000);
    send_word(OP_RIGHT, any_yaw());
    send_word(OP_SAMPLE, 16'sd9000);
    send_word(OP_LEFT, any_yaw());
    send_word(OP_SAMPLE, -16'sd18000);
    send_word(OP_RIGHT, any_yaw());
    send_word(OP_SAMPLE, 16'sh5555);
    send_word(OP_SAMPLE, 16'shAAAA);
    send_word(OP_SAMPLE, 16'sd9200);
    send_word(OP_RIGHT, any_yaw());
    send_word(OP_SAMPLE, -16'sd1);
    send_word(OP_SAMPLE, 16'sd0);
  endtask

  // Main sequence
  initial begin
    int p, sc;
    sb = new();
    calm = 0;
    rst_ni       <= 1'b0;
    cfg_we_i     <= 1'b0;
    cfg_index_i  <= REG_GAIN_P;
    cfg_data_i   <= '0;
    in_valid_i   <= 1'b0;
    operation_i  <= OP_SAMPLE;
    yaw_sample_i <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    run_directed();

    for (p = 0; p < PHASES; p++) begin
      case (p)
        0: program_regs(512, 26, 128, 200, 100, 0);
        1: program_regs(0, 0, 0, 0, 0, 0);
        2: program_regs(65535, 65535, 65535, 0, 100, 0);
        3: program_regs(1, 1, 1, 18000, 127, 127);
        4: program_regs(300, 2000, 40, 50, 20, 60);
        5: program_regs($urandom_range(0, 65535), $urandom_range(0, 65535),
                        $urandom_range(0, 65535), $urandom_range(0, 65535),
                        $urandom_range(0, 65535), $urandom_range(0, 65535));
        default: begin
          sc = $urandom_range(1, 100);
          program_regs($urandom_range(0, 2048), $urandom_range(0, 256),
                       $urandom_range(0, 1024), $urandom_range(0, 1000),
                       sc, $urandom_range(0, sc));
          calm = 1;
        end
      endcase
      run_phase(WORDS_PER_PHASE);
    end

    drain();
    repeat (20) @(posedge clk_i);

    $display("run: %0d words in, %0d words out, %0d turns ended on target",
             sb.words_in, sb.words_out, sb.hits);
    $display("run: directed edge cases, then random turns under %0d register settings",
             settings_used);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/core/htpc_pkg.sv
rtl/core/htpc_queue.sv
rtl/core/htpc_front.sv
rtl/core/htpc_back.sv
rtl/core/heading_turn_pid_controller_core.sv
tb/sv/htpc_tb_pkg.sv
tb/sv/tb_heading_turn_pid_controller_core.sv
